>>> design/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the branch and flag control unit: opcode and
// register-select codes, condition codes, flag bit positions and beat structs.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned OpW   = 6;
  localparam int unsigned SelW  = 3;
  localparam int unsigned CcW   = 4;

  // Instruction codes; codes above OP_WRITE behave as a no-op.
  typedef enum logic [OpW-1:0] {
    OP_NOP    = 6'd0,
    OP_JMP    = 6'd1,
    OP_JO     = 6'd2,
    OP_JG     = 6'd17,
    OP_JCXZ   = 6'd18,
    OP_LOOP   = 6'd19,
    OP_LOOPE  = 6'd20,
    OP_LOOPNE = 6'd21,
    OP_CLC    = 6'd22,
    OP_STC    = 6'd23,
    OP_CMC    = 6'd24,
    OP_CLD    = 6'd25,
    OP_STD    = 6'd26,
    OP_CLI    = 6'd27,
    OP_STI    = 6'd28,
    OP_CBW    = 6'd29,
    OP_CWD    = 6'd30,
    OP_LAHF   = 6'd31,
    OP_SAHF   = 6'd32,
    OP_WRITE  = 6'd33
  } op_t;

  // Conditions of the conditional jumps, in opcode order starting at OP_JO.
  typedef enum logic [CcW-1:0] {
    CC_O, CC_NO, CC_C, CC_NC, CC_E, CC_NE, CC_NA, CC_A,
    CC_S, CC_NS, CC_PE, CC_PO, CC_L, CC_GE, CC_LE, CC_G
  } cc_t;

  // Targets of the register write; codes above SEL_IP write nothing.
  typedef enum logic [SelW-1:0] {
    SEL_AX    = 3'd0,
    SEL_CX    = 3'd1,
    SEL_DX    = 3'd2,
    SEL_FLAGS = 3'd3,
    SEL_IP    = 3'd4
  } sel_t;

  // Flag bit positions.
  localparam int unsigned FlagCf = 0;
  localparam int unsigned FlagPf = 2;
  localparam int unsigned FlagZf = 6;
  localparam int unsigned FlagSf = 7;
  localparam int unsigned FlagIf = 9;
  localparam int unsigned FlagDf = 10;
  localparam int unsigned FlagOf = 11;

  localparam logic [WordW-1:0] FLAGS_RESET = 16'h0002;
  localparam logic [7:0]       AH_MASK     = 8'hD7;
  localparam logic [7:0]       AH_ONE      = 8'h02;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic signed [WordW-1:0] displacement;
    logic                    short_form;
    logic [SelW-1:0]         reg_select;
    logic [WordW-1:0]        write_value;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] flags;
    logic [WordW-1:0] ax;
    logic [WordW-1:0] cx;
    logic [WordW-1:0] dx;
    logic [WordW-1:0] ip;
  } arch_state_t;

  typedef struct packed {
    arch_state_t regs;
    logic        taken;
  } out_beat_t;

endpackage

>>> design/bfc_req_if.sv
// ----------------------------------------------------------------------------
// bfc_req_if
// Instruction channel: valid/ready handshake carrying one instruction a beat.
// ----------------------------------------------------------------------------
interface bfc_req_if;

  logic               valid;
  logic               ready;
  logic [5:0]         opcode;
  logic signed [15:0] displacement;
  logic               short_form;
  logic [2:0]         reg_select;
  logic [15:0]        write_value;

  modport source (
    output valid, opcode, displacement, short_form, reg_select, write_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, displacement, short_form, reg_select, write_value,
    output ready
  );

endinterface

>>> design/bfc_rsp_if.sv
// ----------------------------------------------------------------------------
// bfc_rsp_if
// Result channel: valid/ready handshake carrying the registers and taken bit.
// ----------------------------------------------------------------------------
interface bfc_rsp_if;

  logic        valid;
  logic        ready;
  logic [15:0] ip_out;
  logic [15:0] flags_out;
  logic [15:0] ax_out;
  logic [15:0] cx_out;
  logic [15:0] dx_out;
  logic        taken;

  modport source (
    output valid, ip_out, flags_out, ax_out, cx_out, dx_out, taken,
    input  ready
  );

  modport sink (
    input  valid, ip_out, flags_out, ax_out, cx_out, dx_out, taken,
    output ready
  );

endinterface

>>> design/x86_branch_flag_control_unit_core.sv
// ----------------------------------------------------------------------------
// x86_branch_flag_control_unit_core
// Executes one branch or flag control instruction per beat and returns the
// register set and the taken bit.
// An accepted instruction passes the input register, then the result register,
// which presents its result beat. Throughput: one instruction per cycle while
// rsp.ready does not stall the result, set by the single execute step between the two registers.
// Reset: FLAGS = 0x0002, AX, CX, DX and IP cleared, both stages empty.
// ----------------------------------------------------------------------------
module x86_branch_flag_control_unit_core (
  input  logic      clk,
  input  logic      rst,
  bfc_req_if.sink   req,
  bfc_rsp_if.source rsp
);
  import bfc_pkg::*;

  in_beat_t    in_q;
  logic        in_vld;
  arch_state_t state;
  arch_state_t state_next;
  logic        taken_next;
  out_beat_t   out_q;
  logic        out_vld;
  logic        advance;

  // Execute moves forward when the result register is free or being drained.
  assign advance   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_q.opcode       <= req.opcode;
      in_q.displacement <= req.displacement;
      in_q.short_form   <= req.short_form;
      in_q.reg_select   <= req.reg_select;
      in_q.write_value  <= req.write_value;
    end
  end

  bfc_exec u_exec (
    .beat  (in_q),
    .cur   (state),
    .nxt   (state_next),
    .taken (taken_next)
  );

  // Architectural registers update as each instruction executes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.flags <= FLAGS_RESET;
      state.ax    <= '0;
      state.cx    <= '0;
      state.dx    <= '0;
      state.ip    <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q.regs  <= state_next;
      out_q.taken <= taken_next;
    end
  end

  assign rsp.valid     = out_vld;
  assign rsp.ip_out    = out_q.regs.ip;
  assign rsp.flags_out = out_q.regs.flags;
  assign rsp.ax_out    = out_q.regs.ax;
  assign rsp.cx_out    = out_q.regs.cx;
  assign rsp.dx_out    = out_q.regs.dx;
  assign rsp.taken     = out_q.taken;

  // A freshly executed beat reports exactly the registers it left behind.
  a_result_matches_state: assert property (
    @(posedge clk) disable iff (rst)
    advance |=> (rsp.ip_out == state.ip) && (rsp.cx_out == state.cx) &&
                (rsp.flags_out == state.flags) && (rsp.ax_out == state.ax)
  ) else $error("result beat differs from architectural state");

  // Registers do not move while an instruction waits on a stalled result.
  a_state_holds_on_stall: assert property (
    @(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> $stable(state)
  ) else $error("architectural state changed during a stall");

  // Only jump and loop instructions may report a taken branch.
  a_taken_only_branch: assert property (
    @(posedge clk) disable iff (rst)
    (advance && taken_next) |->
      (in_q.opcode >= OP_JMP) && (in_q.opcode <= OP_LOOPNE)
  ) else $error("taken reported for a non-branch instruction");

  // Loop instructions always decrement CX by one.
  a_loop_decrements_cx: assert property (
    @(posedge clk) disable iff (rst)
    (advance && ((in_q.opcode == OP_LOOP) || (in_q.opcode == OP_LOOPE) ||
                 (in_q.opcode == OP_LOOPNE)))
      |=> state.cx == $past(state.cx) - 16'd1
  ) else $error("loop did not decrement CX");

endmodule

>>> design/bfc_cond.sv
// ----------------------------------------------------------------------------
// bfc_cond
// Evaluates one of the sixteen jump conditions against the flags register.
// ----------------------------------------------------------------------------
module bfc_cond (
  input  logic [bfc_pkg::WordW-1:0] flags,
  input  logic [bfc_pkg::CcW-1:0]   cc,
  output logic                      hold
);
  import bfc_pkg::*;

  logic cf;
  logic zf;
  logic sf;
  logic of;
  logic pf;

  assign cf = flags[FlagCf];
  assign zf = flags[FlagZf];
  assign sf = flags[FlagSf];
  assign of = flags[FlagOf];
  assign pf = flags[FlagPf];

  // Condition decode; every code is defined.
  always_comb begin
    unique case (cc_t'(cc))
      CC_O:    hold = of;
      CC_NO:   hold = !of;
      CC_C:    hold = cf;
      CC_NC:   hold = !cf;
      CC_E:    hold = zf;
      CC_NE:   hold = !zf;
      CC_NA:   hold = cf || zf;
      CC_A:    hold = !cf && !zf;
      CC_S:    hold = sf;
      CC_NS:   hold = !sf;
      CC_PE:   hold = pf;
      CC_PO:   hold = !pf;
      CC_L:    hold = sf != of;
      CC_GE:   hold = sf == of;
      CC_LE:   hold = zf || (sf != of);
      default: hold = !zf && (sf == of);
    endcase
  end

endmodule

>>> design/bfc_exec.sv
// ----------------------------------------------------------------------------
// bfc_exec
// Executes one instruction: computes the next register state and whether a
// branch is taken. Purely combinational.
// ----------------------------------------------------------------------------
module bfc_exec (
  input  bfc_pkg::in_beat_t    beat,
  input  bfc_pkg::arch_state_t cur,
  output bfc_pkg::arch_state_t nxt,
  output logic                 taken
);
  import bfc_pkg::*;

  op_t              op;
  logic [CcW-1:0]   cc;
  logic             cond_hold;
  logic [WordW-1:0] offset;
  logic [WordW-1:0] cx_dec;
  logic             zf_ok;

  assign op = op_t'(beat.opcode);
  assign cc = CcW'(beat.opcode - OP_JO);

  bfc_cond u_cond (
    .flags (cur.flags),
    .cc    (cc),
    .hold  (cond_hold)
  );

  // Short displacements use only the low byte, sign-extended.
  assign offset = beat.short_form
                ? {{8{beat.displacement[7]}}, beat.displacement[7:0]}
                : beat.displacement;

  // Loop forms decrement CX before the test.
  assign cx_dec = cur.cx - 16'd1;

  always_comb begin
    zf_ok = 1'b1;
    if (op == OP_LOOPE) begin
      zf_ok = cur.flags[FlagZf];
    end else if (op == OP_LOOPNE) begin
      zf_ok = !cur.flags[FlagZf];
    end
  end

  // Instruction decode and register update.
  always_comb begin
    nxt   = cur;
    taken = 1'b0;
    unique case (op) inside
      OP_JMP: begin
        taken = 1'b1;
      end
      [OP_JO:OP_JG]: begin
        taken = cond_hold;
      end
      OP_JCXZ: begin
        taken = (cur.cx == '0);
      end
      OP_LOOP, OP_LOOPE, OP_LOOPNE: begin
        nxt.cx = cx_dec;
        taken  = (cx_dec != '0) && zf_ok;
      end
      OP_CLC: nxt.flags[FlagCf] = 1'b0;
      OP_STC: nxt.flags[FlagCf] = 1'b1;
      OP_CMC: nxt.flags[FlagCf] = !cur.flags[FlagCf];
      OP_CLD: nxt.flags[FlagDf] = 1'b0;
      OP_STD: nxt.flags[FlagDf] = 1'b1;
      OP_CLI: nxt.flags[FlagIf] = 1'b0;
      OP_STI: nxt.flags[FlagIf] = 1'b1;
      OP_CBW: nxt.ax = {{8{cur.ax[7]}}, cur.ax[7:0]};
      OP_CWD: nxt.dx = {WordW{cur.ax[15]}};
      OP_LAHF: nxt.ax[15:8] = (cur.flags[7:0] & AH_MASK) | AH_ONE;
      OP_SAHF: nxt.flags[7:0] = (cur.ax[15:8] & AH_MASK) | AH_ONE;
      OP_WRITE: begin
        unique case (sel_t'(beat.reg_select))
          SEL_AX:    nxt.ax    = beat.write_value;
          SEL_CX:    nxt.cx    = beat.write_value;
          SEL_DX:    nxt.dx    = beat.write_value;
          SEL_FLAGS: nxt.flags = beat.write_value;
          SEL_IP:    nxt.ip    = beat.write_value;
          default:   ;
        endcase
      end
      default: ;
    endcase

    // A taken branch adds the offset to IP, wrapping at 16 bits.
    if (taken) begin
      nxt.ip = cur.ip + offset;
    end
  end

endmodule
